// ===== hw/rtl/cfpb_pkg.sv =====
// ----------------------------------------------------------------------------
// cfpb_pkg
// Shared types and constants of the framed packet builder: frame formats,
// register indexes, header constants and the command passed from the front
// end to the back end.
// ----------------------------------------------------------------------------
package cfpb_pkg;

	typedef enum logic [1:0] {
		FMT_PLAIN = 2'd0,
		FMT_FULL  = 2'd1,
		FMT_SHORT = 2'd2,
		FMT_FLAG  = 2'd3
	} fmt_t;

	localparam logic REG_FORMAT = 1'b0;
	localparam logic REG_MAGIC  = 1'b1;

	localparam logic [7:0] MAGIC_RESET  = 8'hEB;
	localparam logic [7:0] MAX_PAYLOAD  = 8'd250;
	localparam logic [7:0] FLAG_FULL    = 8'h3F;
	localparam logic [7:0] FLAG_SHORT   = 8'h03;
	localparam logic [7:0] FLAG_NONE    = 8'h00;
	localparam logic [7:0] NEWLINE      = 8'h0A;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic        hdr;
		logic        dat;
		logic        ftr;
		fmt_t        fmt;
		logic [7:0]  magic;
		logic [15:0] mission;
		logic [7:0]  len;
		logic [7:0]  data;
		logic [7:0]  sig;
		logic [7:0]  snr;
		logic [31:0] epoch;
	} cmd_t;

endpackage

// ===== hw/rtl/crc_framed_packet_builder.sv =====
// ----------------------------------------------------------------------------
// crc_framed_packet_builder
// Builds framed byte streams with a header, payload, optional footer and a
// CRC16-CCITT trailer from payload items marked first and last.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_stall   data_byte .. epoch_seconds
//  out      output     out_valid / out_stall out_byte, end_of_frame
//  cfg      input      cfg_write             cfg_index, cfg_data
//
// The output emits one byte per cycle, unless stalled, from a registered
// output stage; an item holds the byte sequencer until all its bytes are out.
// Items enter a four-entry command queue and are accepted back to back
// until the queue fills. Reset clears the frame state and sets the CRC to
// all ones; configuration takes effect on the next accepted item.
module crc_framed_packet_builder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              has_byte,
	input  logic              first_item,
	input  logic              last_item,
	input  logic [15:0]       mission_id,
	input  logic [9:0]        payload_length,
	input  logic signed [7:0] signal_strength,
	input  logic signed [7:0] signal_noise_ratio,
	input  logic [31:0]       epoch_seconds,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              end_of_frame
);
	import cfpb_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic push;
	logic pop;
	logic full;
	logic nonempty;
	logic accept;

	assign in_stall = full;
	assign accept   = in_valid & ~full;

	cfpb_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.accept             (accept),
		.data_byte          (data_byte),
		.has_byte           (has_byte),
		.first_item         (first_item),
		.last_item          (last_item),
		.mission_id         (mission_id),
		.payload_length     (payload_length),
		.signal_strength    (signal_strength),
		.signal_noise_ratio (signal_noise_ratio),
		.epoch_seconds      (epoch_seconds),
		.push               (push),
		.cmd                (front_cmd)
	);

	cfpb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.full     (full),
		.nonempty (nonempty)
	);

	cfpb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_cmd     (head_cmd),
		.nonempty     (nonempty),
		.pop          (pop),
		.out_byte     (out_byte),
		.end_of_frame (end_of_frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule

// ===== hw/rtl/cfpb_front.sv =====
// ----------------------------------------------------------------------------
// cfpb_front
// Accepts input items, tracks the open frame and the payload count, and
// turns every item that produces output into a command for the back end.
// Also holds the configuration registers.
// ----------------------------------------------------------------------------
module cfpb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 has_byte,
	input  logic                 first_item,
	input  logic                 last_item,
	input  logic [15:0]          mission_id,
	input  logic [9:0]           payload_length,
	input  logic signed [7:0]    signal_strength,
	input  logic signed [7:0]    signal_noise_ratio,
	input  logic [31:0]          epoch_seconds,
	output logic                 push,
	output cfpb_pkg::cmd_t       cmd
);
	import cfpb_pkg::*;

	fmt_t       fmt_q;
	logic [7:0] magic_q;
	logic       open_q;
	logic [7:0] taken_q;
	logic [7:0] limit_q;

	logic       open_eff;
	logic [7:0] lim_eff;
	logic [7:0] taken_eff;
	logic [7:0] lim_clamp;
	logic       do_data;
	logic       do_foot;

	always_comb begin
		lim_clamp = (payload_length > {2'b00, MAX_PAYLOAD}) ? MAX_PAYLOAD : payload_length[7:0];
		open_eff  = first_item | open_q;
		lim_eff   = first_item ? lim_clamp : limit_q;
		taken_eff = first_item ? 8'd0 : taken_q;
		do_data   = open_eff & has_byte & (taken_eff < lim_eff);
		do_foot   = open_eff & last_item;
		push      = accept & (first_item | do_data | do_foot);
	end

	always_comb begin
		cmd.hdr     = first_item;
		cmd.dat     = do_data;
		cmd.ftr     = do_foot;
		cmd.fmt     = fmt_q;
		cmd.magic   = magic_q;
		cmd.mission = mission_id;
		cmd.len     = lim_clamp;
		cmd.data    = data_byte;
		cmd.sig     = $unsigned(signal_strength);
		cmd.snr     = $unsigned(signal_noise_ratio);
		cmd.epoch   = epoch_seconds;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= FMT_PLAIN;
			magic_q <= MAGIC_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FORMAT: fmt_q   <= fmt_t'(cfg_data[1:0]);
				REG_MAGIC:  magic_q <= cfg_data;
				default:    magic_q <= magic_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			taken_q <= 8'd0;
			limit_q <= 8'd0;
		end else if (in_valid && accept) begin
			if (first_item) begin
				limit_q <= lim_clamp;
			end
			if (do_foot) begin
				open_q  <= 1'b0;
				taken_q <= 8'd0;
			end else begin
				open_q  <= open_eff;
				taken_q <= do_data ? taken_eff + 8'd1 : taken_eff;
			end
		end
	end

endmodule

// ===== hw/rtl/cfpb_queue.sv =====
// ----------------------------------------------------------------------------
// cfpb_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cfpb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cfpb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output cfpb_pkg::cmd_t head_cmd,
	output logic           full,
	output logic           nonempty
);
	import cfpb_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;

	assign head_cmd = entry_q[rd_q];
	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cfpb_back.sv =====
// ----------------------------------------------------------------------------
// cfpb_back
// Byte sequencer: walks the output slots of one command, one byte per cycle
// while not stalled, keeps the running CRC and drives the output register.
// ----------------------------------------------------------------------------
module cfpb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cfpb_pkg::cmd_t head_cmd,
	input  logic           nonempty,
	output logic           pop,
	output logic [7:0]     out_byte,
	output logic           end_of_frame,
	output logic           out_valid,
	input  logic           out_stall
);
	import cfpb_pkg::*;

	localparam logic [3:0] SL_MAGIC  = 4'd0;
	localparam logic [3:0] SL_ID_LO  = 4'd1;
	localparam logic [3:0] SL_ID_HI  = 4'd2;
	localparam logic [3:0] SL_FLAG   = 4'd3;
	localparam logic [3:0] SL_LEN    = 4'd4;
	localparam logic [3:0] SL_DATA   = 4'd5;
	localparam logic [3:0] SL_SIG    = 4'd6;
	localparam logic [3:0] SL_SNR    = 4'd7;
	localparam logic [3:0] SL_EP0    = 4'd8;
	localparam logic [3:0] SL_EP1    = 4'd9;
	localparam logic [3:0] SL_EP2    = 4'd10;
	localparam logic [3:0] SL_EP3    = 4'd11;
	localparam logic [3:0] SL_CRC_LO = 4'd12;
	localparam logic [3:0] SL_CRC_HI = 4'd13;
	localparam logic [3:0] SL_EOL    = 4'd14;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [14:0] slot_mask(input cmd_t c);
		logic [14:0] m;
		logic        sig_snr;
		logic        ep;
		sig_snr = (c.fmt == FMT_FULL) || (c.fmt == FMT_SHORT);
		ep      = (c.fmt == FMT_FULL);
		m = '0;
		m[SL_MAGIC]  = c.hdr;
		m[SL_ID_LO]  = c.hdr;
		m[SL_ID_HI]  = c.hdr;
		m[SL_FLAG]   = c.hdr & (c.fmt != FMT_PLAIN);
		m[SL_LEN]    = c.hdr;
		m[SL_DATA]   = c.dat;
		m[SL_SIG]    = c.ftr & sig_snr;
		m[SL_SNR]    = c.ftr & sig_snr;
		m[SL_EP0]    = c.ftr & ep;
		m[SL_EP1]    = c.ftr & ep;
		m[SL_EP2]    = c.ftr & ep;
		m[SL_EP3]    = c.ftr & ep;
		m[SL_CRC_LO] = c.ftr;
		m[SL_CRC_HI] = c.ftr;
		m[SL_EOL]    = c.ftr;
		return m;
	endfunction

	cmd_t        cmd_q;
	logic        active_q;
	logic [14:0] mask_q;
	logic [15:0] crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        eof_q;

	logic [3:0]  slot;
	logic [14:0] mask_rest;
	logic [7:0]  flag;
	logic [7:0]  byte_sel;
	logic [15:0] crc_base;
	logic        emit;
	logic        cmd_done;

	always_comb begin
		slot = SL_EOL;
		for (int i = 14; i >= 0; i--) begin
			if (mask_q[i]) begin
				slot = 4'(i);
			end
		end
		mask_rest = mask_q & ~(15'd1 << slot);
	end

	always_comb begin
		case (cmd_q.fmt)
			FMT_FULL:  flag = FLAG_FULL;
			FMT_SHORT: flag = FLAG_SHORT;
			default:   flag = FLAG_NONE;
		endcase
	end

	always_comb begin
		case (slot)
			SL_MAGIC:  byte_sel = cmd_q.magic;
			SL_ID_LO:  byte_sel = cmd_q.mission[7:0];
			SL_ID_HI:  byte_sel = cmd_q.mission[15:8];
			SL_FLAG:   byte_sel = flag;
			SL_LEN:    byte_sel = cmd_q.len;
			SL_DATA:   byte_sel = cmd_q.data;
			SL_SIG:    byte_sel = cmd_q.sig;
			SL_SNR:    byte_sel = cmd_q.snr;
			SL_EP0:    byte_sel = cmd_q.epoch[7:0];
			SL_EP1:    byte_sel = cmd_q.epoch[15:8];
			SL_EP2:    byte_sel = cmd_q.epoch[23:16];
			SL_EP3:    byte_sel = cmd_q.epoch[31:24];
			SL_CRC_LO: byte_sel = crc_q[7:0];
			SL_CRC_HI: byte_sel = crc_q[15:8];
			default:   byte_sel = NEWLINE;
		endcase
	end

	assign crc_base = (slot == SL_MAGIC) ? CRC_INIT : crc_q;
	assign emit     = active_q & (~out_valid_q | ~out_stall);
	assign cmd_done = emit & (mask_rest == '0);
	assign pop      = nonempty & (~active_q | cmd_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			mask_q      <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				mask_q   <= slot_mask(head_cmd);
			end else if (cmd_done) begin
				active_q <= 1'b0;
				mask_q   <= '0;
			end else if (emit) begin
				mask_q <= mask_rest;
			end
			if (emit) begin
				if (slot < SL_CRC_LO) begin
					crc_q <= crc_byte(crc_base, byte_sel);
				end else if (slot == SL_EOL) begin
					crc_q <= CRC_INIT;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head_cmd;
		end
		if (emit) begin
			out_byte_q <= byte_sel;
			eof_q      <= (slot == SL_EOL);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign end_of_frame = eof_q;

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for crc_framed_packet_builder. A directed table
// covers reset values, header extremes, length clamping, abandoned frames,
// ignored items and every frame format. Random frames then run under three
// idle patterns, including a long receiver stall. Every output byte is
// compared with table bytes or a local model of framer and CRC16 trailer.
// ----------------------------------------------------------------------------
module tb;
	import cfpb_pkg::*;

	localparam int SETTLE_CYCLES = 32;
	localparam int LONG_HOLD     = 200;
	localparam int RUN_LIMIT     = 2000000;

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        first;
		logic        last;
		logic [15:0] mission;
		logic [9:0]  plen;
		logic [7:0]  sig;
		logic [7:0]  snr;
		logic [31:0] epoch;
	} frame_item_t;

	typedef struct packed {
		logic [7:0] value;
		logic       eof;
	} stream_byte_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic        reg_idx;
		logic [7:0]  reg_val;
		frame_item_t item;
		int          n_typed;
		logic [47:0] typed;
	} directed_row_t;

	localparam frame_item_t NO_ITEM = '0;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic              cfg_index = REG_FORMAT;
	logic [7:0]        cfg_data = 8'h00;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte = 8'h00;
	logic              has_byte = 1'b0;
	logic              first_item = 1'b0;
	logic              last_item = 1'b0;
	logic [15:0]       mission_id = 16'h0000;
	logic [9:0]        payload_length = 10'd0;
	logic signed [7:0] signal_strength = 8'sd0;
	logic signed [7:0] signal_noise_ratio = 8'sd0;
	logic [31:0]       epoch_seconds = 32'h0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        out_byte;
	logic              end_of_frame;

	// Local copy of the framer state and its registers.
	fmt_t        cur_format = FMT_PLAIN;
	logic [7:0]  cur_magic = 8'hEB;
	logic [15:0] frame_crc = 16'hFFFF;
	logic [7:0]  frame_taken = 8'd0;
	logic [7:0]  frame_limit = 8'd0;
	logic        frame_open = 1'b0;

	stream_byte_t step_bytes[$];
	stream_byte_t bytes_due[$];

	int mismatches = 0;
	int items_sent = 0;
	int send_idle_pct = 19;
	int recv_idle_pct = 46;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	directed_row_t directed_rows [25] = '{
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h55, 3'b101, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b010, 16'h1234, 10'd2, 8'h00, 8'h00, 32'h0}, 4, 48'hEB34_1202_0000},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b100, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, 1, 48'h0000_0000_0000},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'hFF, 3'b101, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, -1, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b011, 16'hFFFF, 10'd0, 8'h00, 8'h00, 32'h0}, -1, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'hFF, 3'b110, 16'h0000, 10'h3FF, 8'h00, 8'h00, 32'h0}, 5, 48'hEB00_00FA_FF00},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'hA5, 3'b110, 16'h00FF, 10'd1, 8'h00, 8'h00, 32'h0}, 5, 48'hEBFF_0001_A500},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h11, 3'b101, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, -1, 48'h0},
		'{ROW_CFG, REG_FORMAT, {6'd0, FMT_FULL}, NO_ITEM, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h80, 3'b111, 16'h8001, 10'd250, 8'h80, 8'h7F, 32'hFFFF_FFFF}, -1, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b011, 16'h7FFE, 10'd3, 8'h7F, 8'h80, 32'h0}, -1, 48'h0},
		'{ROW_CFG, REG_FORMAT, {6'd0, FMT_SHORT}, NO_ITEM, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h7F, 3'b110, 16'h5AA5, 10'd3, 8'h00, 8'h00, 32'h0}, 6, 48'hEBA5_5A03_037F},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h01, 3'b101, 16'h0000, 10'd0, 8'hFF, 8'h01, 32'h1234_5678}, -1, 48'h0},
		'{ROW_CFG, REG_FORMAT, {6'd0, FMT_FLAG}, NO_ITEM, 0, 48'h0},
		'{ROW_CFG, REG_MAGIC, 8'h00, NO_ITEM, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b010, 16'h0000, 10'd251, 8'h00, 8'h00, 32'h0}, 5, 48'h0000_0000_FA00},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'hC3, 3'b101, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, -1, 48'h0},
		'{ROW_CFG, REG_MAGIC, 8'hFF, NO_ITEM, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b111, 16'h0001, 10'd1, 8'h01, 8'hFE, 32'h8000_0001}, -1, 48'h0},
		'{ROW_CFG, REG_FORMAT, {6'd0, FMT_PLAIN}, NO_ITEM, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h00, 3'b001, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h3C, 3'b100, 16'h0000, 10'd0, 8'h00, 8'h00, 32'h0}, 0, 48'h0},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'hFF, 3'b110, 16'hFFFF, 10'h0FF, 8'h00, 8'h00, 32'h0}, 5, 48'hFFFF_FFFA_FF00},
		'{ROW_ITEM, REG_FORMAT, 8'h00,
			{8'h42, 3'b111, 16'h0102, 10'd1, 8'h00, 8'h00, 32'h0}, -1, 48'h0}
	};

	crc_framed_packet_builder dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.data_byte          (data_byte),
		.has_byte           (has_byte),
		.first_item         (first_item),
		.last_item          (last_item),
		.mission_id         (mission_id),
		.payload_length     (payload_length),
		.signal_strength    (signal_strength),
		.signal_noise_ratio (signal_noise_ratio),
		.epoch_seconds      (epoch_seconds),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.out_byte           (out_byte),
		.end_of_frame       (end_of_frame)
	);

	always #5 clk = ~clk;

	task automatic emit_data(input logic [7:0] b);
		step_bytes.push_back(stream_byte_t'{b, 1'b0});
		frame_crc = frame_crc ^ {b, 8'h00};
		repeat (8) begin
			frame_crc = frame_crc[15] ? ((frame_crc << 1) ^ 16'h1021) : (frame_crc << 1);
		end
	endtask

	task automatic build_frame_bytes(input frame_item_t it);
		logic [7:0] flag;
		step_bytes.delete();
		case (cur_format)
			FMT_FULL: begin
				flag = 8'h3F;
			end
			FMT_SHORT: begin
				flag = 8'h03;
			end
			default: begin
				flag = 8'h00;
			end
		endcase
		if (it.first) begin
			frame_crc = 16'hFFFF;
			frame_taken = 8'd0;
			frame_limit = (it.plen > 10'd250) ? 8'd250 : it.plen[7:0];
			frame_open = 1'b1;
			emit_data(cur_magic);
			emit_data(it.mission[7:0]);
			emit_data(it.mission[15:8]);
			if (cur_format != FMT_PLAIN) begin
				emit_data(flag);
			end
			emit_data(frame_limit);
		end
		if (frame_open && it.has && frame_taken < frame_limit) begin
			emit_data(it.data);
			frame_taken = frame_taken + 8'd1;
		end
		if (frame_open && it.last) begin
			if (flag[0]) begin
				emit_data(it.sig);
			end
			if (flag[1]) begin
				emit_data(it.snr);
			end
			if ((flag & 8'h3C) != 8'h00) begin
				emit_data(it.epoch[7:0]);
				emit_data(it.epoch[15:8]);
				emit_data(it.epoch[23:16]);
				emit_data(it.epoch[31:24]);
			end
			step_bytes.push_back(stream_byte_t'{frame_crc[7:0], 1'b0});
			step_bytes.push_back(stream_byte_t'{frame_crc[15:8], 1'b0});
			step_bytes.push_back(stream_byte_t'{8'h0A, 1'b1});
			frame_open = 1'b0;
			frame_crc = 16'hFFFF;
			frame_taken = 8'd0;
		end
	endtask

	task automatic offer(input frame_item_t it, input bit predicted);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{data_byte, has_byte, first_item, last_item, mission_id, payload_length,
			signal_strength, signal_noise_ratio, epoch_seconds} <= it;
		do @(posedge clk); while (in_stall);
		if (it.first || frame_open) begin
			items_sent++;
		end
		build_frame_bytes(it);
		if (predicted) begin
			foreach (step_bytes[i]) begin
				bytes_due.push_back(step_bytes[i]);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		if (idx == REG_FORMAT) begin
			cur_format = fmt_t'(val[1:0]);
		end else begin
			cur_magic = val;
		end
	endtask

	task automatic send_frame(input int n_items, input bit long_plen);
		frame_item_t it;
		bit noise;
		bit broken;
		noise = ($urandom_range(99) < 8);
		broken = ($urandom_range(99) < 10);
		for (int i = 0; i < n_items; i++) begin
			it.data = 8'($urandom);
			it.mission = 16'($urandom);
			it.sig = 8'($urandom);
			it.snr = 8'($urandom);
			it.epoch = $urandom;
			if (long_plen) begin
				it.plen = 10'($urandom_range(251, 1023));
			end else if ($urandom_range(99) < 85) begin
				it.plen = 10'($urandom_range(0, 14));
			end else begin
				it.plen = 10'($urandom);
			end
			it.has = long_plen || ($urandom_range(9) != 0);
			if (noise) begin
				it.first = ($urandom_range(9) == 0);
				it.last = ($urandom_range(1) == 1);
			end else begin
				it.first = (i == 0);
				it.last = (i == n_items - 1) && !broken;
			end
			offer(it, 1'b1);
		end
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_asks != hold_seen) begin
			out_stall <= 1'b1;
			hold_seen <= hold_asks;
			hold_left <= LONG_HOLD;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		stream_byte_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (bytes_due.size() == 0) begin
				$display("%0t: unexpected byte: expected none, actual %h eof %b",
					$time, out_byte, end_of_frame);
				mismatches++;
			end else begin
				want = bytes_due.pop_front();
				if (out_byte !== want.value) begin
					$display("%0t: out_byte mismatch: expected %h, actual %h",
						$time, want.value, out_byte);
					mismatches++;
				end
				if (end_of_frame !== want.eof) begin
					$display("%0t: end_of_frame mismatch: expected %b, actual %b",
						$time, want.eof, end_of_frame);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int target;
		int setting;
		fmt_t next_fmt;
		logic [7:0] next_magic;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_CFG) begin
				drain();
				write_reg(directed_rows[r].reg_idx, directed_rows[r].reg_val);
			end else begin
				offer(directed_rows[r].item, directed_rows[r].n_typed < 0);
				for (int k = 0; k < directed_rows[r].n_typed; k++) begin
					bytes_due.push_back(
						stream_byte_t'{directed_rows[r].typed[47 - 8 * k -: 8], 1'b0});
				end
			end
		end

		// Three idle patterns, two register settings each.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 46 : 0;
			recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 19 : 0;
			for (int sub = 0; sub < 2; sub++) begin
				setting = 2 * phase + sub;
				case (setting)
					0: next_fmt = FMT_FULL;
					1: next_fmt = FMT_SHORT;
					2: next_fmt = FMT_FLAG;
					3: next_fmt = FMT_PLAIN;
					4: next_fmt = FMT_FULL;
					default: next_fmt = fmt_t'(2'($urandom_range(3)));
				endcase
				next_magic = (setting == 0) ? 8'h00 : (setting == 1) ? 8'hFF : 8'($urandom);
				drain();
				write_reg(REG_FORMAT, {6'd0, next_fmt});
				write_reg(REG_MAGIC, next_magic);
				if (setting == 4) begin
					// The receiver stalls for a long stretch while a long frame
					// whose declared length is above the payload limit keeps coming in.
					hold_asks++;
					send_frame(40, 1'b1);
				end
				target = items_sent + 30;
				while (items_sent < target) begin
					send_frame($urandom_range(1, 12), 1'b0);
				end
			end
		end

		drain();
		if (mismatches == 0) begin
			$display("crc_framed_packet_builder regression: pass");
		end else begin
			$display("crc_framed_packet_builder regression: fail");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT);
		$display("crc_framed_packet_builder regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cfpb_pkg.sv
hw/rtl/cfpb_front.sv
hw/rtl/cfpb_queue.sv
hw/rtl/cfpb_back.sv
hw/rtl/crc_framed_packet_builder.sv
verif/tb.sv
